// ===== rtl/swmms_pkg.sv =====
`default_nettype none

package swmms_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int POS_BITS       = 16;
    localparam int SUM_BITS       = 48;
    localparam int WIN_CFG_BITS   = 7;
    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [WIN_CFG_BITS-1:0] WIN_SIZE_RST = WIN_CFG_BITS'(3);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first;
        logic                          last;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] window_min;
        logic signed [SAMPLE_BITS-1:0] window_max;
        logic signed [SUM_BITS-1:0]    running_sum;
        logic                          final_res;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EV_RD,
        S_EV_CHK,
        S_PB_RD,
        S_PB_CHK,
        S_PUSH,
        S_HD_RD,
        S_HD_CAP,
        S_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic cap_in;
        logic deq;        // 0: maximum deque, 1: minimum deque
        logic rd_head;
        logic rd_back;
        logic ev_pop;
        logic pb_pop;
        logic push;
        logic cap_head;
        logic finish;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic age_old;
        logic keep;
        logic emit;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/swmms_ram.sv =====
`default_nettype none

module swmms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/swmms_ctrl.sv =====
`default_nettype none

module swmms_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire swmms_pkg::t_sts i_sts,
    output swmms_pkg::t_cmd      o_cmd,
    output logic                 o_in_stall
);

    swmms_pkg::t_state r_state;
    swmms_pkg::t_state n_state;
    logic              r_deq;
    logic              n_deq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swmms_pkg::S_IDLE;
            r_deq   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_deq   <= n_deq;
        end
    end

    always_comb begin
        n_state = r_state;
        n_deq   = r_deq;
        unique case (r_state)
            swmms_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = swmms_pkg::S_EV_RD;
                    n_deq   = 1'b0;
                end
            end
            swmms_pkg::S_EV_RD: begin
                n_state = i_sts.cnt_zero ? swmms_pkg::S_PB_RD : swmms_pkg::S_EV_CHK;
            end
            swmms_pkg::S_EV_CHK: begin
                n_state = i_sts.age_old ? swmms_pkg::S_EV_RD : swmms_pkg::S_PB_RD;
            end
            swmms_pkg::S_PB_RD: begin
                n_state = i_sts.cnt_zero ? swmms_pkg::S_PUSH : swmms_pkg::S_PB_CHK;
            end
            swmms_pkg::S_PB_CHK: begin
                n_state = i_sts.keep ? swmms_pkg::S_PUSH : swmms_pkg::S_PB_RD;
            end
            swmms_pkg::S_PUSH: begin
                n_state = swmms_pkg::S_HD_RD;
            end
            swmms_pkg::S_HD_RD: begin
                n_state = swmms_pkg::S_HD_CAP;
            end
            swmms_pkg::S_HD_CAP: begin
                if (r_deq) begin
                    n_state = swmms_pkg::S_DONE;
                end else begin
                    n_state = swmms_pkg::S_EV_RD;
                    n_deq   = 1'b1;
                end
            end
            swmms_pkg::S_DONE: begin
                // A result waits here until the output register can take it.
                if (!i_sts.emit || i_sts.out_free) begin
                    n_state = swmms_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swmms_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.deq      = r_deq;
        o_in_stall     = 1'b1;
        unique case (r_state)
            swmms_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.cap_in = i_in_valid;
            end
            swmms_pkg::S_EV_RD: begin
                o_cmd.rd_head = 1'b1;
            end
            swmms_pkg::S_EV_CHK: begin
                o_cmd.ev_pop = i_sts.age_old;
            end
            swmms_pkg::S_PB_RD: begin
                o_cmd.rd_back = 1'b1;
            end
            swmms_pkg::S_PB_CHK: begin
                o_cmd.pb_pop = !i_sts.keep;
            end
            swmms_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
            end
            swmms_pkg::S_HD_RD: begin
                o_cmd.rd_head = 1'b1;
            end
            swmms_pkg::S_HD_CAP: begin
                o_cmd.cap_head = 1'b1;
            end
            swmms_pkg::S_DONE: begin
                o_cmd.finish = !i_sts.emit || i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/swmms_dp.sv =====
`default_nettype none

module swmms_dp #(
    parameter int MAX_WINDOW = swmms_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [swmms_pkg::WIN_CFG_BITS-1:0]  i_cfg_data,
    input  wire swmms_pkg::t_in_word                 i_in_data,
    input  wire swmms_pkg::t_cmd                     i_cmd,
    output swmms_pkg::t_sts                          o_sts,
    input  wire logic                                i_out_stall,
    output logic                                     o_out_valid,
    output swmms_pkg::t_out_word                     o_out_data
);

    localparam int SB    = swmms_pkg::SAMPLE_BITS;
    localparam int PW    = swmms_pkg::POS_BITS;
    localparam int TW    = swmms_pkg::SUM_BITS;
    localparam int XW    = TW + 2;
    localparam int IW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = CW + 1;
    localparam int EW    = PW + SB;
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;

    localparam logic [SW-1:0]        MAXW_S = SW'(MAX_WINDOW);
    localparam logic [PW-1:0]        MAXW_P = PW'(MAX_WINDOW);
    localparam logic [IW-1:0]        HEAD_LAST = IW'(MAX_WINDOW - 1);
    localparam logic signed [XW-1:0] SUM_HI = XW'((64'sd1 <<< (TW - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] SUM_LO = -SUM_HI - XW'(1);

    logic [swmms_pkg::WIN_CFG_BITS-1:0] r_win_size;
    logic [IW-1:0]                      r_head [2];
    logic [CW-1:0]                      r_cnt  [2];
    logic [PW-1:0]                      r_pos;
    logic signed [TW-1:0]               r_total;
    logic                               r_full;
    logic                               r_out_valid;

    logic signed [SB-1:0]               r_sample;
    logic                               r_last;
    logic [CW-1:0]                      r_w;
    logic signed [SB-1:0]               r_max;
    logic signed [SB-1:0]               r_min;
    swmms_pkg::t_out_word               r_out_data;

    logic [IW-1:0]        head_d;
    logic [CW-1:0]        cnt_d;
    logic [SW-1:0]        tail_sum;
    logic [SW-1:0]        back_sum;
    logic [IW-1:0]        tail_idx;
    logic [IW-1:0]        back_idx;
    logic [IW-1:0]        head_nx;
    logic [EW-1:0]        rdata;
    logic [PW-1:0]        rd_pos;
    logic signed [SB-1:0] rd_val;
    logic [PW-1:0]        age;
    logic [PW:0]          pos_inc;
    logic                 fills;
    logic                 emit;
    logic                 out_free;
    logic [PW-1:0]        win_ext;
    logic [PW-1:0]        win_eff;
    logic signed [XW-1:0] sum_w;
    logic signed [TW-1:0] sum_sat;

    always_comb begin
        head_d   = r_head[i_cmd.deq];
        cnt_d    = r_cnt[i_cmd.deq];
        tail_sum = SW'(head_d) + SW'(cnt_d);
        back_sum = tail_sum - SW'(1);
        tail_idx = (tail_sum >= MAXW_S) ? IW'(tail_sum - MAXW_S) : IW'(tail_sum);
        back_idx = (back_sum >= MAXW_S) ? IW'(back_sum - MAXW_S) : IW'(back_sum);
        head_nx  = (head_d == HEAD_LAST) ? '0 : head_d + IW'(1);
    end

    swmms_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr ({i_cmd.deq, tail_idx}),
        .i_wdata ({r_pos, r_sample}),
        .i_re    (i_cmd.rd_head | i_cmd.rd_back),
        .i_raddr ({i_cmd.deq, (i_cmd.rd_back ? back_idx : head_d)}),
        .o_rdata (rdata)
    );

    always_comb begin
        rd_pos  = rdata[EW-1:SB];
        rd_val  = $signed(rdata[SB-1:0]);
        // Positions wrap; the difference is exact since no entry outlives the window.
        age     = r_pos - rd_pos;
        pos_inc = {1'b0, r_pos} + (PW + 1)'(1);
        fills   = pos_inc >= (PW + 1)'(r_w);
        emit    = r_full | fills | r_last;
        out_free = !r_out_valid || !i_out_stall;

        win_ext = PW'(r_win_size);
        if (r_win_size == '0) begin
            win_eff = PW'(1);
        end else if (win_ext > MAXW_P) begin
            win_eff = MAXW_P;
        end else begin
            win_eff = win_ext;
        end

        sum_w = XW'(r_total) + XW'(r_max) + XW'(r_min);
        if (sum_w > SUM_HI) begin
            sum_sat = TW'(SUM_HI);
        end else if (sum_w < SUM_LO) begin
            sum_sat = TW'(SUM_LO);
        end else begin
            sum_sat = TW'(sum_w);
        end

        o_sts.cnt_zero = (cnt_d == '0);
        o_sts.cnt_full = (SW'(cnt_d) == MAXW_S);
        o_sts.age_old  = age >= PW'(r_w);
        o_sts.keep     = i_cmd.deq ? (rd_val < r_sample) : (rd_val > r_sample);
        o_sts.emit     = emit;
        o_sts.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size  <= swmms_pkg::WIN_SIZE_RST;
            r_head[0]   <= '0;
            r_head[1]   <= '0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win_size <= i_cfg_data;
            end
            if (i_cmd.cap_in && i_in_data.first) begin
                r_head[0] <= '0;
                r_head[1] <= '0;
                r_cnt[0]  <= '0;
                r_cnt[1]  <= '0;
                r_pos     <= '0;
                r_total   <= '0;
                r_full    <= 1'b0;
            end
            if (i_cmd.ev_pop) begin
                r_head[i_cmd.deq] <= head_nx;
                r_cnt[i_cmd.deq]  <= cnt_d - CW'(1);
            end
            if (i_cmd.pb_pop) begin
                r_cnt[i_cmd.deq] <= cnt_d - CW'(1);
            end
            if (i_cmd.push) begin
                r_cnt[i_cmd.deq] <= cnt_d + CW'(1);
            end
            if (i_cmd.finish) begin
                r_pos  <= PW'(pos_inc);
                r_full <= r_full | fills;
                if (emit) begin
                    r_total <= sum_sat;
                end
            end
            if (i_cmd.finish && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_sample <= i_in_data.sample;
            r_last   <= i_in_data.last;
            r_w      <= CW'(win_eff);
        end
        if (i_cmd.cap_head) begin
            if (i_cmd.deq) begin
                r_min <= rd_val;
            end else begin
                r_max <= rd_val;
            end
        end
        if (i_cmd.finish && emit) begin
            r_out_data.window_min  <= r_min;
            r_out_data.window_max  <= r_max;
            r_out_data.running_sum <= sum_sat;
            r_out_data.final_res   <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_min_max_sum.sv =====
// Sliding window minimum and maximum with a saturating running sum of min+max.
//
// Input channel: i_in_valid / o_in_stall carry one word {sample, first, last}.
// A word with first set restarts the sequence: both deques, the position and
// the sum are cleared before the sample is taken. Output channel:
// o_out_valid / i_out_stall carry {window_min, window_max, running_sum,
// final_res}. A result appears for every word once the window has filled,
// and for a word with last set even if the window is still partial.
// The window size is written through i_cfg_we / i_cfg_data while idle.
//
// One word is processed at a time. Both deques share one RAM with a
// registered read, so each deque step is a read state followed by a check
// state, and each sample is popped at most once per deque. The result is
// registered, so it appears in the cycle after the word finishes.
//
// Reset clears the deques, the position, the sum and sets the window to 3.
// While the output register holds an unaccepted result, a new result waits
// inside the block and o_in_stall stays high; no result is ever dropped.
`default_nettype none

module sliding_window_min_max_sum #(
    parameter int MAX_WINDOW = swmms_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [swmms_pkg::WIN_CFG_BITS-1:0] i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire swmms_pkg::t_in_word                i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output swmms_pkg::t_out_word                    o_out_data
);

    swmms_pkg::t_cmd cmd;
    swmms_pkg::t_sts sts;

    swmms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    swmms_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // The RAM port and the deque updates are never asked for twice at once.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.rd_head, cmd.rd_back, cmd.push, cmd.cap_head, cmd.finish}))
        else $error("conflicting datapath commands");

    // Eviction leaves room, so a push never meets a full deque.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> !sts.cnt_full)
        else $error("push into a full deque");

    // An accepted word keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word accepted while busy");

endmodule

`default_nettype wire
